// File: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

  // Item widths
  localparam int ANGLE_W = 24;             // Q7.16 angle
  localparam int VALUE_W = 18;             // Q1.16 result
  localparam int SHIFT_W = ANGLE_W + 1;    // angle after the sine shift
  localparam int MAG_W   = ANGLE_W;        // |angle|, up to 8491552
  localparam int ARG_W   = 17;             // folded angle, 0..pi/2

  // Angle constants in Q16
  localparam logic [MAG_W-1:0] PI_Q16      = 24'd205887;
  localparam logic [MAG_W-1:0] TWO_PI_Q16  = 24'd411775;
  localparam logic [MAG_W-1:0] HALF_PI_Q16 = 24'd102944;

  // Modulo 2*pi: conditional subtract of 16, 8, 4, 2, 1 times 2*pi
  localparam int RED_STEPS = 5;

  // Front pipeline: shift, abs, reduction steps, fold
  localparam int FRONT_STAGES = RED_STEPS + 3;
  // Back pipeline: x2, x4, x6/x8, x10/x12, estimate, correct, sum
  localparam int BACK_STAGES  = 7;
  // Accept edge to the edge at which the result is taken
  localparam int LATENCY      = FRONT_STAGES + 1 + BACK_STAGES;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [ARG_W-1:0] arg;    // angle folded into 0..pi/2, Q16
    logic             flip;   // negate the polynomial
  } cst_item_t;

endpackage

`default_nettype wire

// File: rtl/core/cst_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_front
  import cst_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [ANGLE_W-1:0] angle,
  input  wire logic                      req_type,
  output logic                           busy,
  output logic                           item_valid,
  output cst_item_t                      item,
  input  wire logic                      item_ready
);

  logic                      adv;
  logic [FRONT_STAGES-1:0]   vld_r, vld_nxt;
  logic signed [SHIFT_W-1:0] ang_r, ang_nxt;
  logic [MAG_W-1:0]          red_r   [RED_STEPS+1];
  logic [MAG_W-1:0]          red_nxt [RED_STEPS+1];
  logic [MAG_W-1:0]          half_turn;
  logic                      fold_flip;
  cst_item_t                 item_r, item_nxt;

  // whole pipeline moves together; holds only if the queue is full
  assign adv        = !(vld_r[FRONT_STAGES-1] && !item_ready);
  assign busy       = !adv;
  assign item_valid = vld_r[FRONT_STAGES-1];
  assign item       = item_r;

  always_comb begin
    vld_nxt = {vld_r[FRONT_STAGES-2:0], start};
    ang_nxt = SHIFT_W'(angle) - (req_type ? SHIFT_W'(HALF_PI_Q16) : SHIFT_W'(0));
    red_nxt[0] = ang_r[SHIFT_W-1] ? MAG_W'(-ang_r) : MAG_W'(ang_r);
    for (int k = 0; k < RED_STEPS; k++) begin
      if (red_r[k] >= (TWO_PI_Q16 << (RED_STEPS - 1 - k))) begin
        red_nxt[k+1] = red_r[k] - (TWO_PI_Q16 << (RED_STEPS - 1 - k));
      end else begin
        red_nxt[k+1] = red_r[k];
      end
    end
    // fold into 0..pi, then 0..pi/2
    half_turn = (red_r[RED_STEPS] > PI_Q16) ? TWO_PI_Q16 - red_r[RED_STEPS]
                                            : red_r[RED_STEPS];
    fold_flip = half_turn > HALF_PI_Q16;
    item_nxt.flip = fold_flip;
    item_nxt.arg  = fold_flip ? ARG_W'(PI_Q16 - half_turn) : ARG_W'(half_turn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r <= ang_nxt;
      for (int k = 0; k <= RED_STEPS; k++) begin
        red_r[k] <= red_nxt[k];
      end
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cst_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_queue
  import cst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  input  wire cst_item_t wr_item,
  output logic           wr_ready,
  output logic           rd_valid,
  output cst_item_t      rd_item
);

  cst_item_t         slot_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    cnt_r, cnt_nxt;
  logic              push, pop;

  // back end never stalls: head leaves whenever present
  assign wr_ready = cnt_r != QCW'(QDEPTH);
  assign push     = wr_valid && wr_ready;
  assign pop      = cnt_r != '0;
  assign rd_valid = pop;
  assign rd_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cst_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_back
  import cst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_valid,
  input  wire cst_item_t item,
  output logic           out_valid,
  output logic [VALUE_W-1:0] out_value
);

  // power widths (Q28)
  localparam int X2_W  = 30;
  localparam int X4_W  = 31;
  localparam int X6_W  = 32;
  localparam int X8_W  = 34;
  localparam int X10_W = 35;
  localparam int X12_W = 36;
  // term widths
  localparam int T2_W  = 29;
  localparam int T4_W  = 27;
  localparam int T6_W  = 23;
  localparam int T8_W  = 18;
  localparam int T10_W = 13;
  localparam int T12_W = 7;
  localparam int OP_W  = 36;
  localparam int MAG_OUT_W = 17;

  localparam logic [OP_W-1:0] D4  = 36'd24;
  localparam logic [OP_W-1:0] D6  = 36'd720;
  localparam logic [OP_W-1:0] D8  = 36'd40320;
  localparam logic [OP_W-1:0] D10 = 36'd3628800;
  localparam logic [OP_W-1:0] D12 = 36'd479001600;
  // reciprocal shifts: 2^S exceeds every numerator, so the estimate is q or q-1
  localparam int S4  = X4_W;
  localparam int S6  = X6_W;
  localparam int S8  = X8_W;
  localparam int S10 = X10_W;
  localparam int S12 = X12_W;
  localparam logic [63:0] M4  = (64'd1 << S4)  / 64'd24;
  localparam logic [63:0] M6  = (64'd1 << S6)  / 64'd720;
  localparam logic [63:0] M8  = (64'd1 << S8)  / 64'd40320;
  localparam logic [63:0] M10 = (64'd1 << S10) / 64'd3628800;
  localparam logic [63:0] M12 = (64'd1 << S12) / 64'd479001600;
  localparam logic [71:0] Q28_RND = 72'd1 << 27;
  localparam logic signed [31:0] Q28_ONE = 32'sd268435456;

  function automatic logic [OP_W-1:0] mul_q28(input logic [OP_W-1:0] a,
                                              input logic [OP_W-1:0] b);
    logic [71:0] p;
    p = 72'(a) * 72'(b) + Q28_RND;
    return p[63:28];
  endfunction

  function automatic logic [OP_W-1:0] recip_est(input logic [OP_W-1:0] n,
                                                input logic [63:0] m,
                                                input int unsigned sh);
    logic [99:0] p;
    p = 100'(n) * 100'(m);
    return OP_W'(p >> sh);
  endfunction

  function automatic logic [OP_W-1:0] recip_fix(input logic [OP_W-1:0] n,
                                                input logic [OP_W-1:0] q,
                                                input logic [OP_W-1:0] d);
    logic [OP_W-1:0] rem;
    rem = n - q * d;
    return (rem >= d) ? q + OP_W'(1) : q;
  endfunction

  logic [BACK_STAGES-1:0]   vld_r;
  logic [BACK_STAGES-2:0]   flip_r;

  // stage 0..3: powers
  logic [X2_W-1:0]  x2a_r, x2b_r, x2c_r, x2d_r, x2a_nxt;
  logic [X4_W-1:0]  x4a_r, x4b_r, x4c_r, x4a_nxt;
  logic [X6_W-1:0]  x6a_r, x6b_r, x6a_nxt;
  logic [X8_W-1:0]  x8a_r, x8b_r, x8a_nxt;
  logic [X10_W-1:0] x10a_r, x10a_nxt;
  logic [X12_W-1:0] x12a_r, x12a_nxt;
  // stage 4: rounded numerators and quotient estimates
  logic [T2_W-1:0]  t2a_r, t2b_r, t2a_nxt;
  logic [X4_W-1:0]  n4_r, n4_nxt;
  logic [X6_W-1:0]  n6_r, n6_nxt;
  logic [X8_W-1:0]  n8_r, n8_nxt;
  logic [X10_W-1:0] n10_r, n10_nxt;
  logic [X12_W-1:0] n12_r, n12_nxt;
  logic [T4_W-1:0]  e4_r, e4_nxt;
  logic [T6_W-1:0]  e6_r, e6_nxt;
  logic [T8_W-1:0]  e8_r, e8_nxt;
  logic [T10_W-1:0] e10_r, e10_nxt;
  logic [T12_W-1:0] e12_r, e12_nxt;
  // stage 5: exact terms
  logic [T4_W-1:0]  t4_r, t4_nxt;
  logic [T6_W-1:0]  t6_r, t6_nxt;
  logic [T8_W-1:0]  t8_r, t8_nxt;
  logic [T10_W-1:0] t10_r, t10_nxt;
  logic [T12_W-1:0] t12_r, t12_nxt;
  // stage 6: sum and output
  logic signed [31:0]     sum;
  logic [28:0]            sum_clamped;
  logic [MAG_OUT_W-1:0]   mag_q16;
  logic [VALUE_W-1:0]     value_r, value_nxt;

  assign out_valid = vld_r[BACK_STAGES-1];
  assign out_value = value_r;

  always_comb begin
    x2a_nxt  = X2_W'((34'(item.arg) * 34'(item.arg) + 34'd8) >> 4);
    x4a_nxt  = X4_W'(mul_q28(OP_W'(x2a_r), OP_W'(x2a_r)));
    x6a_nxt  = X6_W'(mul_q28(OP_W'(x4a_r), OP_W'(x2b_r)));
    x8a_nxt  = X8_W'(mul_q28(OP_W'(x4a_r), OP_W'(x4a_r)));
    x10a_nxt = X10_W'(mul_q28(OP_W'(x8a_r), OP_W'(x2c_r)));
    x12a_nxt = X12_W'(mul_q28(OP_W'(x8a_r), OP_W'(x4b_r)));

    t2a_nxt = T2_W'((x2d_r + X2_W'(1)) >> 1);
    n4_nxt  = x4c_r  + X4_W'(D4 >> 1);
    n6_nxt  = x6b_r  + X6_W'(D6 >> 1);
    n8_nxt  = x8b_r  + X8_W'(D8 >> 1);
    n10_nxt = x10a_r + X10_W'(D10 >> 1);
    n12_nxt = x12a_r + X12_W'(D12 >> 1);
    e4_nxt  = T4_W'(recip_est(OP_W'(n4_nxt), M4, S4));
    e6_nxt  = T6_W'(recip_est(OP_W'(n6_nxt), M6, S6));
    e8_nxt  = T8_W'(recip_est(OP_W'(n8_nxt), M8, S8));
    e10_nxt = T10_W'(recip_est(OP_W'(n10_nxt), M10, S10));
    e12_nxt = T12_W'(recip_est(OP_W'(n12_nxt), M12, S12));

    t4_nxt  = T4_W'(recip_fix(OP_W'(n4_r), OP_W'(e4_r), D4));
    t6_nxt  = T6_W'(recip_fix(OP_W'(n6_r), OP_W'(e6_r), D6));
    t8_nxt  = T8_W'(recip_fix(OP_W'(n8_r), OP_W'(e8_r), D8));
    t10_nxt = T10_W'(recip_fix(OP_W'(n10_r), OP_W'(e10_r), D10));
    t12_nxt = T12_W'(recip_fix(OP_W'(n12_r), OP_W'(e12_r), D12));

    sum = Q28_ONE - 32'(t2b_r) + 32'(t4_r) - 32'(t6_r) + 32'(t8_r)
        - 32'(t10_r) + 32'(t12_r);
    priority if (sum < 32'sd0) begin
      sum_clamped = '0;
    end else if (sum > Q28_ONE) begin
      sum_clamped = 29'(Q28_ONE);
    end else begin
      sum_clamped = 29'(sum);
    end
    mag_q16   = MAG_OUT_W'((30'(sum_clamped) + 30'd2048) >> 12);
    value_nxt = flip_r[BACK_STAGES-2] ? -VALUE_W'(mag_q16) : VALUE_W'(mag_q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[BACK_STAGES-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    flip_r <= {flip_r[BACK_STAGES-3:0], item.flip};
    x2a_r  <= x2a_nxt;
    x2b_r  <= x2a_r;
    x4a_r  <= x4a_nxt;
    x2c_r  <= x2b_r;
    x4b_r  <= x4a_r;
    x6a_r  <= x6a_nxt;
    x8a_r  <= x8a_nxt;
    x2d_r  <= x2c_r;
    x4c_r  <= x4b_r;
    x6b_r  <= x6a_r;
    x8b_r  <= x8a_r;
    x10a_r <= x10a_nxt;
    x12a_r <= x12a_nxt;
    t2a_r  <= t2a_nxt;
    n4_r   <= n4_nxt;
    n6_r   <= n6_nxt;
    n8_r   <= n8_nxt;
    n10_r  <= n10_nxt;
    n12_r  <= n12_nxt;
    e4_r   <= e4_nxt;
    e6_r   <= e6_nxt;
    e8_r   <= e8_nxt;
    e10_r  <= e10_nxt;
    e12_r  <= e12_nxt;
    t2b_r  <= t2a_r;
    t4_r   <= t4_nxt;
    t6_r   <= t6_nxt;
    t8_r   <= t8_nxt;
    t10_r  <= t10_nxt;
    t12_r  <= t12_nxt;
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/cosine_sine_taylor.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          handshake
// -------   -----------------------------  ------------------------------------
// in        in_angle[23:0], in_req_type    taken at clk edge with start & !busy
// out       out_value[17:0]                one cycle, marked by out_valid
//
// One item per cycle, back to back.
// The rate is set by the front pipeline, which moves one item per cycle
// into a 4-entry queue; the back pipeline drains one item per cycle.
// Reset (rst_n low, synchronous) empties both pipelines and the queue.
// The receiver cannot stall; busy rises only if the queue were to fill.

module cosine_sine_taylor
  import cst_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [ANGLE_W-1:0] in_angle,
  input  wire logic                      in_req_type,
  output logic                           out_valid,
  output logic signed [VALUE_W-1:0]      out_value
);

  // front -> queue
  logic      fr_valid;
  logic      fr_ready;
  cst_item_t fr_item;
  // queue -> back
  logic      bk_valid;
  cst_item_t bk_item;
  logic [VALUE_W-1:0] bk_value;

  // Front: sine shift (angle - pi/2), abs, modulo 2*pi by five
  // conditional subtracts, fold to 0..pi/2 with the sign flip.
  cst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .angle      (in_angle),
    .req_type   (in_req_type),
    .busy       (busy),
    .item_valid (fr_valid),
    .item       (fr_item),
    .item_ready (fr_ready)
  );

  // Short queue decouples the two halves.
  cst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_item  (fr_item),
    .wr_ready (fr_ready),
    .rd_valid (bk_valid),
    .rd_item  (bk_item)
  );

  // Back: even powers in Q28, terms divided by factorials through
  // reciprocal estimate plus one-step correction, sum, clamp, round to Q16.
  cst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (bk_valid),
    .item       (bk_item),
    .out_valid  (out_valid),
    .out_value  (bk_value)
  );

  assign out_value = $signed(bk_value);

endmodule

`default_nettype wire

// File: rtl/core/cst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_checker
  import cst_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [VALUE_W-1:0] out_value
);

  // result never beyond +-1.0
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_value) >= -18'sd65536 &&
                   $signed(out_value) <= 18'sd65536))
    else $error("result out of range");

  // every result comes from an item accepted a fixed latency earlier
  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // back end drains every cycle, so the queue never backs up
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("front stalled");

endmodule

bind cosine_sine_taylor cst_checker u_cst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_value (out_value)
);

`default_nettype wire
